### rtl/iuhb_pkg.sv
// Package for the Ethernet/IPv4/UDP header builder.
// Holds header constants, register index codes and shared widths; no dependencies.
`default_nettype none

package iuhb_pkg;

	localparam int unsigned WordBits   = 64;
	localparam int unsigned NumWords   = 6;
	localparam int unsigned BufBits    = WordBits * NumWords;
	localparam int unsigned HdrBits    = 336;
	localparam int unsigned MacBits    = 48;
	localparam int unsigned IpBits     = 32;
	localparam int unsigned PortBits   = 16;
	localparam int unsigned LenBits    = 12;
	localparam int unsigned SumBits    = 19;

	localparam logic [LenBits-1:0]  MaxPayload   = 12'd2048;
	localparam logic [MacBits-1:0]  MacBroadcast = 48'hFFFF_FFFF_FFFF;
	localparam logic [15:0]         EthTypeIpv4  = 16'h0800;
	localparam logic [7:0]          IpVerIhl     = 8'h45;
	localparam logic [7:0]          IpTos        = 8'h00;
	localparam logic [15:0]         IpFragment   = 16'h0000;
	localparam logic [7:0]          IpTtl        = 8'd64;
	localparam logic [7:0]          ProtoUdp     = 8'd17;
	localparam logic [15:0]         UdpChecksum  = 16'h0000;
	localparam logic [15:0]         IpHdrUdpLen  = 16'd28;
	localparam logic [15:0]         UdpHdrLen    = 16'd8;
	localparam logic [15:0]         UdpPortReset = 16'd11452;

	localparam logic [3:0]          FullWordBytes = 4'd8;
	localparam logic [3:0]          LastWordBytes = 4'd2;

	typedef enum logic [1:0] {
		REG_SOURCE_MAC = 2'd0,
		REG_SOURCE_IP  = 2'd1,
		REG_UDP_PORT   = 2'd2
	} cfg_idx_t;

endpackage : iuhb_pkg

`default_nettype wire

### rtl/ipv4_udp_frame_header_builder_unit.sv
// Top level of the Ethernet/IPv4/UDP header builder.
// Depends on iuhb_pkg for header constants and register index codes.
//
// Usage: a request word (dest_ip, payload_len) enters on the in_valid/in_ready
// channel. Each request with a length from 1 to 2048 yields six header words on
// the out_valid/out_ready channel, first header byte in the top byte. Words one
// to five carry eight bytes; the sixth carries two and has last_word set. A
// request with length zero or above the maximum is taken and dropped silently.
// Configuration registers (source MAC, source IP, UDP port) are written on the
// cfg channel, which is always ready; writes to an unknown index are ignored.
// The request passes through stage one and stage two into the output buffer, which
// then presents one word per cycle while out_ready is high. The six-word output
// shift buffer takes the next header only as its last word leaves; a two-stage
// input pipeline lets the next request be taken and its checksum summed while
// the previous header is still draining. When the receiver stalls the current
// word holds and the pipeline fills up, then in_ready drops.
// Reset clears all valid flags, the identification counter and the registers
// to their defaults (UDP port 11452).
`default_nettype none

module ipv4_udp_frame_header_builder_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [iuhb_pkg::IpBits-1:0]   dest_ip,
	input  wire logic [iuhb_pkg::LenBits-1:0]  payload_len,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [iuhb_pkg::WordBits-1:0]      header_word,
	output logic [3:0]                         word_bytes,
	output logic                               last_word,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [1:0]                    cfg_index,
	input  wire logic [iuhb_pkg::MacBits-1:0]  cfg_data
);

	import iuhb_pkg::*;

	// Configuration registers.
	logic [MacBits-1:0]  source_mac_q;
	logic [IpBits-1:0]   source_ip_q;
	logic [PortBits-1:0] udp_port_q;
	logic [15:0]         ident_q;

	// Stage one: the accepted request, only kept if its length is legal.
	logic                s1_valid;
	logic [IpBits-1:0]   dest_ip_s1;
	logic [LenBits-1:0]  len_s1;

	// Stage two: request plus its identification and the raw checksum sum.
	logic                s2_valid;
	logic [IpBits-1:0]   dest_ip_s2;
	logic [15:0]         total_len_s2;
	logic [15:0]         ident_s2;
	logic [SumBits-1:0]  sum_s2;

	// Output shift buffer holding the whole header.
	logic                out_valid_q;
	logic [BufBits-1:0]  hdr_q;
	logic [2:0]          word_cnt_q;

	logic                len_ok;
	logic                in_fire;
	logic                buf_free;
	logic                s2_ready;
	logic                s1_adv;
	logic                s2_adv;
	logic                out_fire;
	logic                is_last;
	logic [15:0]         total_len;
	logic [SumBits-1:0]  sum_next;
	logic [16:0]         fold1;
	logic [15:0]         fold2;
	logic [15:0]         checksum;
	logic [15:0]         udp_len;
	logic [HdrBits-1:0]  hdr_build;

	assign cfg_ready = 1'b1;

	assign is_last  = (word_cnt_q == 3'(NumWords - 1));
	assign out_fire = out_valid_q && out_ready;
	// The buffer can take a new header when empty or when its last word leaves now.
	assign buf_free = !out_valid_q || (out_fire && is_last);
	assign s2_adv   = s2_valid && buf_free;
	assign s2_ready = !s2_valid || buf_free;
	assign s1_adv   = s1_valid && s2_ready;
	assign in_ready = !s1_valid || s2_ready;
	assign in_fire  = in_valid && in_ready;
	assign len_ok   = (payload_len != '0) && (payload_len <= MaxPayload);

	// Checksum sum over the IPv4 header with the checksum field at zero.
	// The fixed words (version/IHL/TOS, fragment and TTL/protocol) enter as constant terms.
	assign total_len = 16'(len_s1) + IpHdrUdpLen;
	always_comb begin
		sum_next = SumBits'({IpVerIhl, IpTos}) + SumBits'({IpTtl, ProtoUdp})
			+ SumBits'(IpFragment) + SumBits'(total_len) + SumBits'(ident_q)
			+ SumBits'(source_ip_q[31:16]) + SumBits'(source_ip_q[15:0])
			+ SumBits'(dest_ip_s1[31:16]) + SumBits'(dest_ip_s1[15:0]);
	end

	// Two end-around carry folds bring the sum back to 16 bits.
	assign fold1    = 17'(sum_s2[15:0]) + 17'(sum_s2[SumBits-1:16]);
	assign fold2    = fold1[15:0] + 16'(fold1[16]);
	assign checksum = ~fold2;
	assign udp_len  = total_len_s2 - IpHdrUdpLen + UdpHdrLen;

	assign hdr_build = {
		MacBroadcast, source_mac_q, EthTypeIpv4,
		IpVerIhl, IpTos, total_len_s2, ident_s2, IpFragment,
		IpTtl, ProtoUdp, checksum, source_ip_q, dest_ip_s2,
		udp_port_q, udp_port_q, udp_len, UdpChecksum
	};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_mac_q <= '0;
			source_ip_q  <= '0;
			udp_port_q   <= UdpPortReset;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SOURCE_MAC: source_mac_q <= cfg_data;
				REG_SOURCE_IP:  source_ip_q  <= cfg_data[IpBits-1:0];
				REG_UDP_PORT:   udp_port_q   <= cfg_data[PortBits-1:0];
				default:        ;
			endcase
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid    <= 1'b0;
			s2_valid    <= 1'b0;
			out_valid_q <= 1'b0;
			word_cnt_q  <= '0;
			ident_q     <= '0;
		end else begin
			if (in_fire) begin
				s1_valid <= len_ok;
			end else if (s1_adv) begin
				s1_valid <= 1'b0;
			end

			if (s1_adv) begin
				s2_valid <= 1'b1;
				ident_q  <= ident_q + 16'd1;
			end else if (s2_adv) begin
				s2_valid <= 1'b0;
			end

			if (s2_adv) begin
				out_valid_q <= 1'b1;
				word_cnt_q  <= '0;
			end else if (out_fire) begin
				if (is_last) begin
					out_valid_q <= 1'b0;
				end
				word_cnt_q <= word_cnt_q + 3'd1;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			dest_ip_s1 <= dest_ip;
			len_s1     <= payload_len;
		end
		if (s1_adv) begin
			dest_ip_s2   <= dest_ip_s1;
			total_len_s2 <= total_len;
			ident_s2     <= ident_q;
			sum_s2       <= sum_next;
		end
		if (s2_adv) begin
			hdr_q <= {hdr_build, (BufBits - HdrBits)'(0)};
		end else if (out_fire) begin
			hdr_q <= hdr_q << WordBits;
		end
	end

	assign out_valid   = out_valid_q;
	assign header_word = hdr_q[BufBits-1 -: WordBits];
	assign last_word   = is_last;
	assign word_bytes  = is_last ? LastWordBytes : FullWordBytes;

endmodule : ipv4_udp_frame_header_builder_unit

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for the Ethernet/IPv4/UDP header builder unit.
// Depends on iuhb_pkg for port widths and register index codes; needs only the RTL.
`timescale 1ns / 100ps

module tb_top;
	import iuhb_pkg::*;

	// Index 3 has no register behind it, so a write there must change nothing.
	localparam logic [1:0] RegUnused = 2'd3;

	// Cycles without any handshake after which the run is declared hung.
	localparam int StallLimit = 2000;

	// Cycles the receiver refuses words during the back-pressure test.
	localparam int HoldOffCycles = 96;

	// Cycles allowed after the last expected word before a register write or the
	// final verdict; covers a dropped request still sitting in the input pipeline.
	localparam int SettleCycles = 12;

	typedef struct packed {
		logic [63:0] data;
		logic [3:0]  nbytes;
		logic        last;
	} hdr_word_t;

	// Tracks the register file and identification counter of the block, builds
	// the six header words that each request should produce, and compares the
	// words leaving the block against them in order.
	class udp_header_tracker;
		logic [47:0] mac;
		logic [31:0] src_ip;
		logic [15:0] port;
		logic [15:0] ident;
		hdr_word_t   pending_words[$];
		int          errors;

		function new();
			mac = '0;
			src_ip = '0;
			port = 16'd11452;
			ident = '0;
			errors = 0;
		endfunction

		function void apply_setting(logic [1:0] idx, logic [47:0] value);
			case (idx)
				REG_SOURCE_MAC: mac = value;
				REG_SOURCE_IP:  src_ip = value[31:0];
				REG_UDP_PORT:   port = value[15:0];
				default: ;
			endcase
		endfunction

		function logic [15:0] ip_checksum(logic [159:0] ip);
			logic [31:0] acc;
			int k;
			acc = '0;
			for (k = 0; k < 10; k++)
				acc += ip[159 - 16 * k -: 16];
			while (acc[31:16] != 0)
				acc = acc[15:0] + acc[31:16];
			return ~acc[15:0];
		endfunction

		function void predict_header(logic [31:0] dst, logic [11:0] len);
			logic [159:0] ip;
			logic [383:0] hdr;
			logic [15:0] total_len;
			logic [15:0] udp_len;
			hdr_word_t w;
			int k;
			if (len == 0 || len > 12'd2048)
				return;
			total_len = 16'd28 + len;
			udp_len = 16'd8 + len;
			// Checksum field is zero while the sum is formed, then filled in.
			ip = {8'h45, 8'h00, total_len, ident, 16'h0000, 8'd64, 8'd17, 16'h0000,
				src_ip, dst};
			ip[79:64] = ip_checksum(ip);
			ident = ident + 16'd1;
			hdr = {48'hFFFF_FFFF_FFFF, mac, 16'h0800, ip, port, port, udp_len,
				16'h0000, 48'h0};
			for (k = 0; k < 6; k++) begin
				w.data = hdr[383 - 64 * k -: 64];
				w.nbytes = (k == 5) ? 4'd2 : 4'd8;
				w.last = (k == 5);
				pending_words.push_back(w);
			end
		endfunction

		function void compare_word(logic [63:0] data, logic [3:0] nbytes, logic last);
			hdr_word_t want;
			if (pending_words.size() == 0) begin
				errors++;
				$display("%0t: unexpected header word %h bytes %0d last %0b",
					$time, data, nbytes, last);
				return;
			end
			want = pending_words.pop_front();
			if (data !== want.data) begin
				errors++;
				$display("%0t: header_word expected %h actual %h", $time, want.data, data);
			end
			if (nbytes !== want.nbytes) begin
				errors++;
				$display("%0t: word_bytes expected %0d actual %0d", $time, want.nbytes,
					nbytes);
			end
			if (last !== want.last) begin
				errors++;
				$display("%0t: last_word expected %0b actual %0b", $time, want.last, last);
			end
		endfunction

		function int outstanding();
			return pending_words.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [31:0] dest_ip;
	logic [11:0] payload_len;
	logic        out_valid;
	logic        out_ready;
	logic [63:0] header_word;
	logic [3:0]  word_bytes;
	logic        last_word;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [47:0] cfg_data;

	udp_header_tracker tracker;

	// When set, the matching side never idles; this gives stretches where the
	// block runs at full rate.
	bit calm_sender;
	bit calm_receiver;
	// Raised by the stimulus process to ask the receiver for one long hold-off.
	bit hold_off_req;

	int quiet_cycles;

	ipv4_udp_frame_header_builder_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.dest_ip(dest_ip),
		.payload_len(payload_len),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.header_word(header_word),
		.word_bytes(word_bytes),
		.last_word(last_word),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Offers one request and returns at the rising edge where it is taken. The
	// sender sometimes drops valid for a few cycles first, unless it is calm.
	// Valid that stays high between back-to-back words is never lowered, so each
	// falling edge assigns in_valid at most once.
	task automatic send_request(input logic [31:0] dst, input logic [11:0] len);
		if (!calm_sender && $urandom_range(0, 99) < 16) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat ($urandom_range(0, 3)) @(negedge clk);
		end
		@(negedge clk);
		in_valid = 1'b1;
		dest_ip = dst;
		payload_len = len;
		do
			@(posedge clk);
		while (!in_ready);
		tracker.predict_header(dst, len);
	endtask

	// Writes one register through the configuration channel.
	task automatic write_reg(input logic [1:0] idx, input logic [47:0] value);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		do
			@(posedge clk);
		while (!cfg_ready);
		tracker.apply_setting(idx, value);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Stops offering requests and waits until every predicted word has been
	// seen, then a few more cycles so that a dropped request cannot still be in
	// flight when the registers change.
	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (tracker.outstanding() != 0)
			@(negedge clk);
		repeat (SettleCycles) @(negedge clk);
	endtask

	// One random phase: fresh register settings, then a stream of requests in
	// which most lengths are legal and a small share are dropped ones. Only
	// legal requests count toward the phase length.
	task automatic run_phase(input int n_legal, input bit calm, input bit squeeze);
		logic [31:0] dst;
		logic [11:0] len;
		int legal;
		int pick;
		write_reg(REG_SOURCE_MAC, 48'({$urandom, $urandom}));
		write_reg(REG_SOURCE_IP, {16'h0, $urandom});
		write_reg(REG_UDP_PORT, {32'h0, 16'($urandom)});
		if ($urandom_range(0, 1) == 1)
			write_reg(RegUnused, 48'({$urandom, $urandom}));
		calm_sender = calm;
		calm_receiver = calm;
		legal = 0;
		while (legal < n_legal) begin
			pick = $urandom_range(0, 99);
			if (pick < 8)
				len = ($urandom_range(0, 1) == 1) ? 12'd0 : 12'($urandom_range(2049, 4095));
			else if (pick < 20)
				len = ($urandom_range(0, 1) == 1) ? 12'd1 : 12'(2049 - $urandom_range(1, 2));
			else
				len = 12'($urandom_range(1, 2048));
			pick = $urandom_range(0, 99);
			if (pick < 5)
				dst = 32'h0;
			else if (pick < 10)
				dst = 32'hFFFF_FFFF;
			else
				dst = $urandom;
			send_request(dst, len);
			if (len != 0 && len <= 12'd2048)
				legal++;
			// The request is already taken here, so the receiver starts its
			// hold-off while the sender keeps pushing until in_ready drops.
			if (squeeze && legal == 4)
				hold_off_req = 1'b1;
		end
		settle();
		calm_sender = 1'b0;
		calm_receiver = 1'b0;
	endtask

	// Receiver: random stalls on every cycle, none while calm, and one long
	// hold-off on request that it counts out itself.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				out_ready = 1'b0;
				repeat (HoldOffCycles) @(negedge clk);
				hold_off_req = 1'b0;
			end else begin
				out_ready = calm_receiver || ($urandom_range(0, 99) >= 16);
			end
		end
	end

	// Every word that leaves the block is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			tracker.compare_word(header_word, word_bytes, last_word);
	end

	// Watchdog: counts cycles in which no channel moves a word.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= StallLimit) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		tracker = new();
		quiet_cycles = 0;
		calm_sender = 1'b0;
		calm_receiver = 1'b0;
		hold_off_req = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		dest_ip = '0;
		payload_len = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part under the reset settings: shortest and longest legal
		// lengths, all-zero and all-one addresses, alternating bit patterns, and
		// zero and oversized lengths, which must vanish without using an ident.
		send_request(32'h0000_0000, 12'd1);
		send_request(32'hFFFF_FFFF, 12'd2048);
		send_request(32'h0A00_0001, 12'd0);
		send_request(32'h0A00_0002, 12'd2049);
		send_request(32'hC0A8_0101, 12'hFFF);
		send_request(32'hA5A5_A5A5, 12'h555);
		send_request(32'h5A5A_5A5A, 12'h2AA);
		settle();

		// Registers at their all-ones / zero extremes.
		write_reg(REG_SOURCE_MAC, 48'hFFFF_FFFF_FFFF);
		write_reg(REG_SOURCE_IP, 48'h0000_FFFF_FFFF);
		write_reg(REG_UDP_PORT, 48'h0);
		send_request(32'hFFFF_FFFF, 12'd2048);
		send_request(32'h0000_0000, 12'd1);
		send_request(32'h1234_5678, 12'd1000);
		settle();

		// The opposite extremes, then a write to the unused index that must not
		// disturb any register.
		write_reg(REG_SOURCE_MAC, 48'h0);
		write_reg(REG_SOURCE_IP, 48'h0);
		write_reg(REG_UDP_PORT, 48'h0000_0000_FFFF);
		write_reg(RegUnused, 48'hFFFF_FFFF_FFFF);
		send_request(32'h0000_0000, 12'd1);
		send_request(32'hFFFF_FFFF, 12'd2047);
		send_request(32'h8000_0001, 12'd2048);
		send_request(32'h0102_0304, 12'd0);
		send_request(32'h0506_0708, 12'd64);
		settle();

		// Random part: a normal phase, a phase at full rate on both sides, one
		// with a long receiver hold-off so the block backs up, and a last one.
		run_phase(27, 1'b0, 1'b0);
		run_phase(27, 1'b1, 1'b0);
		run_phase(27, 1'b0, 1'b1);
		run_phase(27, 1'b0, 1'b0);

		repeat (SettleCycles) @(negedge clk);
		if (tracker.errors == 0 && tracker.outstanding() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

### sim.f
rtl/iuhb_pkg.sv
rtl/ipv4_udp_frame_header_builder_unit.sv
tb/tb_top.sv
